[hdl/iqonc_pkg.sv]
// ----------------------------------------------------------------------------
// IQ offset nulling calibrator package
// Shared command codes, search constants and the structs that feed the result
// emitter from the sequencer and the configuration registers.
// ----------------------------------------------------------------------------
package iqonc_pkg;

  // Frequency points and register file
  localparam int unsigned NumPoints = 5;
  localparam int unsigned PllW      = 24;
  localparam int unsigned AmpW      = 4;
  localparam int unsigned CodeW     = 16;
  localparam int unsigned MeanW     = 16;
  localparam int unsigned PointW    = 3;
  localparam int unsigned CmdW      = 3;
  localparam int unsigned ValW      = 24;
  localparam int unsigned IdxW      = 3;
  localparam int unsigned MeanAddrW = 4;

  // Configuration register indexes
  localparam logic [IdxW-1:0] REG_PGA_AMP = 3'd0;
  localparam logic [IdxW-1:0] REG_PLL_0   = 3'd1;
  localparam logic [IdxW-1:0] REG_PLL_1   = 3'd2;
  localparam logic [IdxW-1:0] REG_PLL_2   = 3'd3;
  localparam logic [IdxW-1:0] REG_PLL_3   = 3'd4;
  localparam logic [IdxW-1:0] REG_PLL_4   = 3'd5;

  // PLL reset words
  localparam logic [PllW-1:0] PLL_RST_0 = 24'd10241;
  localparam logic [PllW-1:0] PLL_RST_1 = 24'd10321;
  localparam logic [PllW-1:0] PLL_RST_2 = 24'd10529;
  localparam logic [PllW-1:0] PLL_RST_3 = 24'd10609;
  localparam logic [PllW-1:0] PLL_RST_4 = 24'd10817;

  // Input operation codes
  localparam logic OP_START   = 1'b0;
  localparam logic OP_READING = 1'b1;

  // Output command codes
  localparam logic [CmdW-1:0] CMD_PLL = 3'd0;
  localparam logic [CmdW-1:0] CMD_DAC = 3'd1;
  localparam logic [CmdW-1:0] CMD_PGA = 3'd2;
  localparam logic [CmdW-1:0] CMD_REQ = 3'd3;
  localparam logic [CmdW-1:0] CMD_RPT = 3'd4;

  // Search constants
  localparam logic [MeanW-1:0] MIDSCALE    = 16'h8000;
  localparam logic [CodeW-1:0] COARSE_STEP = 16'h0100;
  localparam logic [CodeW-1:0] FINE_STEP   = 16'h0010;
  localparam logic [CodeW-1:0] LIMIT_I     = 16'h0FFF;
  localparam logic [CodeW-1:0] LIMIT_Q     = 16'h1FFF;
  localparam logic [CodeW-1:0] START_I     = 16'h0000;
  localparam logic [CodeW-1:0] START_Q     = 16'h1000;
  localparam logic [7:0]       PGA_TAG     = 8'h2A;
  localparam logic [7:0]       PT_TAG      = 8'hF0;
  localparam logic [7:0]       SYNC_BYTE   = 8'hFF;

  // Burst layout: last byte position of each kind (per point for a report)
  localparam logic [2:0] BEGIN_LAST  = 3'd4;
  localparam logic [2:0] PAIR_LAST   = 3'd1;
  localparam logic [2:0] RPT_LAST    = 3'd6;
  localparam logic [PointW-1:0] LAST_POINT = 3'd4;

  typedef enum logic [1:0] {
    BK_BEGIN,
    BK_STEP,
    BK_SWITCH,
    BK_REPORT
  } burst_kind_e;

  typedef struct packed {
    burst_kind_e       kind;
    logic [PointW-1:0] point;
    logic [CodeW-1:0]  code;
  } burst_t;

  typedef struct packed {
    logic                 en;
    logic [MeanAddrW-1:0] addr;
    logic [MeanW-1:0]     data;
  } mean_wr_t;

  typedef struct packed {
    logic [AmpW-1:0]                 pga_amp;
    logic [NumPoints-1:0][PllW-1:0]  pll_word;
  } cfg_t;

endpackage

[hdl/iq_offset_null_calibrator.sv]
// ----------------------------------------------------------------------------
// IQ offset nulling calibrator
// Five-point I/Q offset search: PLL, DAC, PGA and ADC request commands and a
// final 35-byte report.
// ----------------------------------------------------------------------------
// Throughput: one result per cycle while out_ready_i is high; an item holds the
// emitter for the length of its burst (0, 2, 5 or 35 results), and one further
// item waits in the input register meanwhile.
// Reset: asynchronous, active low; clears control state, loads register defaults.
module iq_offset_null_calibrator (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [iqonc_pkg::IdxW-1:0]    cfg_idx_i,
  input  logic [iqonc_pkg::PllW-1:0]    cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          operation_i,
  input  logic [iqonc_pkg::MeanW-1:0]   adc_mean_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [iqonc_pkg::CmdW-1:0]    command_o,
  output logic [iqonc_pkg::ValW-1:0]    value_o,
  output logic                          last_o
);

  iqonc_pkg::cfg_t      cfg_q;
  iqonc_pkg::burst_t    burst;
  iqonc_pkg::mean_wr_t  mean_wr;
  logic                 load;
  logic                 emit_ready;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pga_amp     <= '0;
      cfg_q.pll_word[0] <= iqonc_pkg::PLL_RST_0;
      cfg_q.pll_word[1] <= iqonc_pkg::PLL_RST_1;
      cfg_q.pll_word[2] <= iqonc_pkg::PLL_RST_2;
      cfg_q.pll_word[3] <= iqonc_pkg::PLL_RST_3;
      cfg_q.pll_word[4] <= iqonc_pkg::PLL_RST_4;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        iqonc_pkg::REG_PGA_AMP: cfg_q.pga_amp     <= cfg_wdata_i[iqonc_pkg::AmpW-1:0];
        iqonc_pkg::REG_PLL_0:   cfg_q.pll_word[0] <= cfg_wdata_i;
        iqonc_pkg::REG_PLL_1:   cfg_q.pll_word[1] <= cfg_wdata_i;
        iqonc_pkg::REG_PLL_2:   cfg_q.pll_word[2] <= cfg_wdata_i;
        iqonc_pkg::REG_PLL_3:   cfg_q.pll_word[3] <= cfg_wdata_i;
        iqonc_pkg::REG_PLL_4:   cfg_q.pll_word[4] <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  iqonc_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .operation_i  (operation_i),
    .adc_mean_i   (adc_mean_i),
    .emit_ready_i (emit_ready),
    .load_o       (load),
    .burst_o      (burst),
    .mean_wr_o    (mean_wr)
  );

  iqonc_emit u_emit (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .mean_wr_i    (mean_wr),
    .load_i       (load),
    .burst_i      (burst),
    .emit_ready_o (emit_ready),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .command_o    (command_o),
    .value_o      (value_o),
    .last_o       (last_o)
  );

endmodule

[hdl/iqonc_ctrl.sv]
// ----------------------------------------------------------------------------
// IQ offset nulling sequencer
// Holds one input item and the search state, steps the DAC code search and
// hands a burst descriptor to the emitter.
// ----------------------------------------------------------------------------
module iqonc_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          operation_i,
  input  logic [iqonc_pkg::MeanW-1:0]   adc_mean_i,
  input  logic                          emit_ready_i,
  output logic                          load_o,
  output iqonc_pkg::burst_t             burst_o,
  output iqonc_pkg::mean_wr_t           mean_wr_o
);

  logic                             item_valid_q;
  logic                             op_q;
  logic [iqonc_pkg::MeanW-1:0]      mean_q;
  logic                             busy_q, busy_d;
  logic [iqonc_pkg::PointW-1:0]     point_q, point_d;
  logic                             chq_q, chq_d;
  logic                             fine_q, fine_d;
  logic [iqonc_pkg::CodeW-1:0]      code_q, code_d;

  logic                             has_burst;
  logic                             fire;
  logic [iqonc_pkg::CodeW-1:0]      limit;
  logic                             below_limit;
  logic                             coarse_ok;
  logic                             fine_ok;

  // Search decisions for a reading
  assign limit       = chq_q ? iqonc_pkg::LIMIT_Q : iqonc_pkg::LIMIT_I;
  assign below_limit = code_q < limit;
  assign coarse_ok   = !fine_q && (mean_q <= iqonc_pkg::MIDSCALE) && below_limit;
  assign fine_ok     = !coarse_ok && (mean_q >= iqonc_pkg::MIDSCALE) && below_limit;

  assign has_burst  = (op_q == iqonc_pkg::OP_START) || busy_q;
  assign fire       = item_valid_q && (!has_burst || emit_ready_i);
  assign in_ready_o = !item_valid_q || fire;
  assign load_o     = fire && has_burst;

  // Next state and burst descriptor
  always_comb begin
    busy_d          = busy_q;
    point_d         = point_q;
    chq_d           = chq_q;
    fine_d          = fine_q;
    code_d          = code_q;
    burst_o.kind    = iqonc_pkg::BK_BEGIN;
    burst_o.point   = '0;
    burst_o.code    = '0;
    mean_wr_o.en    = 1'b0;
    mean_wr_o.addr  = {point_q, chq_q};
    mean_wr_o.data  = mean_q;
    if (op_q == iqonc_pkg::OP_START) begin
      busy_d  = 1'b1;
      point_d = '0;
      chq_d   = 1'b0;
      fine_d  = 1'b0;
      code_d  = iqonc_pkg::START_I;
    end else if (busy_q) begin
      if (coarse_ok || fine_ok) begin
        fine_d       = fine_q || !coarse_ok;
        code_d       = coarse_ok ? code_q + iqonc_pkg::COARSE_STEP
                                 : code_q - iqonc_pkg::FINE_STEP;
        burst_o.kind = iqonc_pkg::BK_STEP;
        burst_o.code = code_d;
      end else if (!chq_q) begin
        mean_wr_o.en = 1'b1;
        chq_d        = 1'b1;
        fine_d       = 1'b0;
        code_d       = iqonc_pkg::START_Q;
        burst_o.kind = iqonc_pkg::BK_SWITCH;
      end else begin
        mean_wr_o.en = 1'b1;
        chq_d        = 1'b0;
        fine_d       = 1'b0;
        if (point_q != iqonc_pkg::LAST_POINT) begin
          point_d       = point_q + 3'd1;
          code_d        = iqonc_pkg::START_I;
          burst_o.kind  = iqonc_pkg::BK_BEGIN;
          burst_o.point = point_d;
        end else begin
          busy_d       = 1'b0;
          point_d      = '0;
          burst_o.kind = iqonc_pkg::BK_REPORT;
        end
      end
    end
    mean_wr_o.en = mean_wr_o.en && fire;
  end

  // Hold the input item until the emitter can take its burst
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      item_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      op_q   <= operation_i;
      mean_q <= adc_mean_i;
    end
  end

  // Advance search state when the item is consumed
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      point_q <= '0;
      chq_q   <= 1'b0;
      fine_q  <= 1'b0;
      code_q  <= '0;
    end else if (fire) begin
      busy_q  <= busy_d;
      point_q <= point_d;
      chq_q   <= chq_d;
      fine_q  <= fine_d;
      code_q  <= code_d;
    end
  end

endmodule

[hdl/iqonc_emit.sv]
// ----------------------------------------------------------------------------
// IQ offset nulling result emitter
// Keeps the final channel means and walks one burst of commands or report
// bytes, one transfer per cycle while out_ready_i is high.
// ----------------------------------------------------------------------------
module iqonc_emit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  iqonc_pkg::cfg_t               cfg_i,
  input  iqonc_pkg::mean_wr_t           mean_wr_i,
  input  logic                          load_i,
  input  iqonc_pkg::burst_t             burst_i,
  output logic                          emit_ready_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [iqonc_pkg::CmdW-1:0]    command_o,
  output logic [iqonc_pkg::ValW-1:0]    value_o,
  output logic                          last_o
);

  logic [iqonc_pkg::MeanW-1:0]      means_q [10];
  logic                             active_q;
  iqonc_pkg::burst_kind_e           kind_q;
  logic [iqonc_pkg::PointW-1:0]     point_q;
  logic [iqonc_pkg::CodeW-1:0]      code_q;
  logic [2:0]                       byte_q;

  logic                             out_fire;
  logic [iqonc_pkg::MeanAddrW-1:0]  rd_addr;
  logic [iqonc_pkg::MeanW-1:0]      rd_mean;
  logic [iqonc_pkg::ValW-1:0]       pga_i_word;
  logic [iqonc_pkg::ValW-1:0]       pga_q_word;
  logic [7:0]                       rpt_byte;

  // Store final means
  always_ff @(posedge clk_i) begin
    if (mean_wr_i.en) begin
      means_q[mean_wr_i.addr] <= mean_wr_i.data;
    end
  end

  // Report byte: I mean in bytes two and three, Q mean in four and five
  assign rd_addr = {point_q, (byte_q >= 3'd4)};
  assign rd_mean = means_q[rd_addr];

  always_comb begin
    case (byte_q)
      3'd2, 3'd4: rpt_byte = rd_mean[15:8];
      3'd3, 3'd5: rpt_byte = rd_mean[7:0];
      3'd6:       rpt_byte = iqonc_pkg::PT_TAG + {5'd0, point_q};
      default:    rpt_byte = iqonc_pkg::SYNC_BYTE;
    endcase
  end

  assign pga_i_word = {8'd0, iqonc_pkg::PGA_TAG, cfg_i.pga_amp, 4'd1};
  assign pga_q_word = {8'd0, iqonc_pkg::PGA_TAG, cfg_i.pga_amp, 4'd0};

  // Select command, value and end of burst
  always_comb begin
    command_o = iqonc_pkg::CMD_REQ;
    value_o   = '0;
    last_o    = 1'b0;
    case (kind_q)
      iqonc_pkg::BK_BEGIN: begin
        last_o = byte_q == iqonc_pkg::BEGIN_LAST;
        case (byte_q)
          3'd0: begin
            command_o = iqonc_pkg::CMD_PLL;
            value_o   = cfg_i.pll_word[point_q];
          end
          3'd1: begin
            command_o = iqonc_pkg::CMD_DAC;
            value_o   = {8'd0, iqonc_pkg::START_I};
          end
          3'd2: begin
            command_o = iqonc_pkg::CMD_DAC;
            value_o   = {8'd0, iqonc_pkg::START_Q};
          end
          3'd3: begin
            command_o = iqonc_pkg::CMD_PGA;
            value_o   = pga_i_word;
          end
          default: begin
            command_o = iqonc_pkg::CMD_REQ;
          end
        endcase
      end
      iqonc_pkg::BK_STEP: begin
        last_o = byte_q == iqonc_pkg::PAIR_LAST;
        if (byte_q == 3'd0) begin
          command_o = iqonc_pkg::CMD_DAC;
          value_o   = {8'd0, code_q};
        end
      end
      iqonc_pkg::BK_SWITCH: begin
        last_o = byte_q == iqonc_pkg::PAIR_LAST;
        if (byte_q == 3'd0) begin
          command_o = iqonc_pkg::CMD_PGA;
          value_o   = pga_q_word;
        end
      end
      default: begin
        last_o    = (point_q == iqonc_pkg::LAST_POINT) && (byte_q == iqonc_pkg::RPT_LAST);
        command_o = iqonc_pkg::CMD_RPT;
        value_o   = {16'd0, rpt_byte};
      end
    endcase
  end

  assign out_valid_o  = active_q;
  assign out_fire     = active_q && out_ready_i;
  assign emit_ready_o = !active_q || (out_fire && last_o);

  // Load a burst or advance through it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      kind_q   <= iqonc_pkg::BK_BEGIN;
      point_q  <= '0;
      byte_q   <= '0;
    end else if (load_i) begin
      active_q <= 1'b1;
      kind_q   <= burst_i.kind;
      point_q  <= burst_i.point;
      byte_q   <= '0;
    end else if (out_fire) begin
      if (last_o) begin
        active_q <= 1'b0;
      end else if ((kind_q == iqonc_pkg::BK_REPORT) && (byte_q == iqonc_pkg::RPT_LAST)) begin
        byte_q  <= '0;
        point_q <= point_q + 3'd1;
      end else begin
        byte_q <= byte_q + 3'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      code_q <= burst_i.code;
    end
  end

endmodule

[hdl/iqonc_checker.sv]
// ----------------------------------------------------------------------------
// IQ offset nulling calibrator checker
// Port-level properties of the calibrator, bound to the top level.
// ----------------------------------------------------------------------------
module iqonc_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [iqonc_pkg::IdxW-1:0]    cfg_idx_i,
  input  logic [iqonc_pkg::PllW-1:0]    cfg_wdata_i,
  input  logic                          in_valid_i,
  input  logic                          in_ready_o,
  input  logic                          operation_i,
  input  logic [iqonc_pkg::MeanW-1:0]   adc_mean_i,
  input  logic                          out_valid_o,
  input  logic                          out_ready_i,
  input  logic [iqonc_pkg::CmdW-1:0]    command_o,
  input  logic [iqonc_pkg::ValW-1:0]    value_o,
  input  logic                          last_o
);

  // Hold command and last while a transfer stalls
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(command_o) && $stable(last_o))
    else $error("result stalled but command or last changed");

  // Input side only backs up while results are pending
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o)
    else $error("input stalled with no result pending");

  // Every ADC request closes its burst and carries a zero value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (command_o == iqonc_pkg::CMD_REQ) |-> last_o && (value_o == '0))
    else $error("ADC request not last or nonzero");

  // A report burst runs unbroken to its end
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && (command_o == iqonc_pkg::CMD_RPT) && !last_o
      |=> out_valid_o && (command_o == iqonc_pkg::CMD_RPT))
    else $error("report burst interrupted");

endmodule

bind iq_offset_null_calibrator iqonc_checker u_iqonc_checker (.*);
